// ===== rtl/core/kpc_pkg.sv =====
// kpc_pkg: shared types, constants and symbol helpers for the keyed polybius cipher
`default_nettype none

package kpc_pkg;

  localparam int CHAR_W      = 8;
  localparam int SYM_W       = 6;
  localparam int DIG_W       = 4;
  localparam int NUM_SYMBOLS = 36;
  localparam int NUM_LETTERS = 26;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;

  typedef enum logic [1:0] {
    ACT_KEY     = 2'd0,
    ACT_FINISH  = 2'd1,
    ACT_ENCRYPT = 2'd2,
    ACT_DECRYPT = 2'd3
  } action_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] idx;
  } sym_lookup_t;

  function automatic sym_lookup_t sym_lookup(input logic [CHAR_W-1:0] c);
    sym_lookup_t r;
    r.ok  = 1'b0;
    r.idx = '0;
    if (c inside {[CH_A:CH_Z]}) begin
      r.ok  = 1'b1;
      r.idx = SYM_W'(c - CH_A);
    end else if (c inside {[CH_ZERO:CH_NINE]}) begin
      r.ok  = 1'b1;
      r.idx = SYM_W'(c - CH_ZERO) + SYM_W'(NUM_LETTERS);
    end
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] sym_char(input logic [SYM_W-1:0] s);
    logic [CHAR_W-1:0] r;
    if (s < SYM_W'(NUM_LETTERS)) begin
      r = CH_A + CHAR_W'(s);
    end else begin
      r = CH_ZERO + CHAR_W'(s - SYM_W'(NUM_LETTERS));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kpc_ram.sv =====
// kpc_ram: generic single write port ram with registered read
`default_nettype none

module kpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 36
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/keyed_polybius_cipher.sv =====
// keyed_polybius_cipher: keyed polybius square cipher top level
// Items are taken one at a time; in_stall stays high until the item's work is done. Key
// items and decrypt items are accepted and executed; a decrypted symbol read from the
// grid ram is presented from a further state. Encrypt items read the symbol's cell index
// from the position ram and split it into row and column, where row is the symbol's grid
// row (0 to GRID_SIDE-1), by one shared compare-and-subtract step per cycle. A finish
// item walks all 36 symbols, one per cycle. Any beat that finds the result register still
// full waits there until it is taken. The result register lets the next item be accepted
// while the last beat of the previous one still waits to be taken.
`default_nettype none

module keyed_polybius_cipher import kpc_pkg::*; #(
  parameter int GRID_SIDE = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_action,
  input  wire logic [CHAR_W-1:0] in_char,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CHAR_W-1:0] out_char,
  output logic                   out_last
);

  localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W    = $clog2(NUM_CELLS);
  localparam int CNT_W     = $clog2(NUM_CELLS + 1);
  localparam int ROW_W     = $clog2(GRID_SIDE);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_EXEC     = 7'b0000010,
    ST_FILL     = 7'b0000100,
    ST_POS_RD   = 7'b0001000,
    ST_DIV      = 7'b0010000,
    ST_EMIT_COL = 7'b0100000,
    ST_GRID_RD  = 7'b1000000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [NUM_SYMBOLS-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]         fill_r, fill_nxt;
  logic [ROW_W-1:0]         prow_r, prow_nxt;
  logic                     pvalid_r, pvalid_nxt;
  logic [SYM_W-1:0]         sym_r, sym_nxt;
  logic [CELL_W-1:0]        rem_r, rem_nxt;
  logic [ROW_W-1:0]         quo_r, quo_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]        out_char_r, out_char_nxt;
  logic                     out_last_r, out_last_nxt;
  action_t                  act_r;
  logic [CHAR_W-1:0]        char_r;

  logic                     grid_we, grid_re;
  logic [CELL_W-1:0]        grid_waddr, grid_raddr;
  logic [CHAR_W-1:0]        grid_wdata, grid_rdata;
  logic                     pos_we, pos_re;
  logic [SYM_W-1:0]         pos_waddr, pos_raddr;
  logic [CELL_W-1:0]        pos_wdata, pos_rdata;

  logic                     place_req, place_ok;
  logic [SYM_W-1:0]         place_sym;
  sym_lookup_t              lk;
  logic [DIG_W-1:0]         dig;
  logic                     is_digit;
  logic [CELL_W-1:0]        dec_idx;
  logic                     out_take, out_free, in_take;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_take  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || out_take;

  assign lk       = sym_lookup(char_r);
  assign dig      = DIG_W'(char_r - CH_ZERO);
  assign is_digit = char_r inside {[CH_ZERO:CH_NINE]};
  assign dec_idx  = CELL_W'(prow_r) * CELL_W'(GRID_SIDE) + CELL_W'(dig);

  assign place_req = ((state_r == ST_EXEC) && (act_r == ACT_KEY) && lk.ok) ||
                     (state_r == ST_FILL);
  assign place_sym = (state_r == ST_FILL) ? sym_r : lk.idx;
  assign place_ok  = place_req && (fill_r < CNT_W'(NUM_CELLS)) && !used_r[place_sym];

  assign grid_we    = place_ok;
  assign grid_waddr = fill_r[CELL_W-1:0];
  assign grid_wdata = sym_char(place_sym);
  assign pos_we     = place_ok;
  assign pos_waddr  = place_sym;
  assign pos_wdata  = fill_r[CELL_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    prow_nxt      = prow_r;
    pvalid_nxt    = pvalid_r;
    sym_nxt       = sym_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    out_valid_nxt = out_valid_r && !out_take;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    grid_re       = 1'b0;
    grid_raddr    = dec_idx;
    pos_re        = 1'b0;
    pos_raddr     = lk.idx;

    if (place_ok) begin
      used_nxt[place_sym] = 1'b1;
      fill_nxt            = fill_r + CNT_W'(1);
    end

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (act_r)
          ACT_KEY: begin
            state_nxt = ST_IDLE;
          end
          ACT_FINISH: begin
            sym_nxt   = '0;
            state_nxt = ST_FILL;
          end
          default: begin
            if (char_r == CH_SPACE) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_char_nxt  = CH_SPACE;
                out_last_nxt  = 1'b1;
                pvalid_nxt    = 1'b0;
                prow_nxt      = '0;
                state_nxt     = ST_IDLE;
              end
            end else if (act_r == ACT_ENCRYPT) begin
              if (lk.ok && used_r[lk.idx]) begin
                pos_re    = 1'b1;
                state_nxt = ST_POS_RD;
              end else begin
                state_nxt = ST_IDLE;
              end
            end else begin
              state_nxt = ST_IDLE;
              if (is_digit) begin
                if (dig >= DIG_W'(GRID_SIDE)) begin
                  pvalid_nxt = 1'b0;
                  prow_nxt   = '0;
                end else if (!pvalid_r) begin
                  prow_nxt   = dig[ROW_W-1:0];
                  pvalid_nxt = 1'b1;
                end else begin
                  grid_re    = 1'b1;
                  pvalid_nxt = 1'b0;
                  prow_nxt   = '0;
                  state_nxt  = ST_GRID_RD;
                end
              end
            end
          end
        endcase
      end
      ST_FILL: begin
        sym_nxt = sym_r + SYM_W'(1);
        if (sym_r == SYM_W'(NUM_SYMBOLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POS_RD: begin
        rem_nxt   = pos_rdata;
        quo_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (rem_r >= CELL_W'(GRID_SIDE)) begin
          rem_nxt = rem_r - CELL_W'(GRID_SIDE);
          quo_nxt = quo_r + ROW_W'(1);
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + CHAR_W'(quo_r);
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT_COL;
        end
      end
      ST_EMIT_COL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_ZERO + CHAR_W'(rem_r);
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_GRID_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = grid_rdata;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      prow_r      <= '0;
      pvalid_r    <= 1'b0;
      sym_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      prow_r      <= prow_nxt;
      pvalid_r    <= pvalid_nxt;
      sym_r       <= sym_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (in_take) begin
      act_r  <= action_t'(in_action);
      char_r <= in_char;
    end
  end

  kpc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (NUM_CELLS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (grid_we),
    .waddr (grid_waddr),
    .wdata (grid_wdata),
    .re    (grid_re),
    .raddr (grid_raddr),
    .rdata (grid_rdata)
  );

  kpc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

endmodule

`default_nettype wire
